// ----- rtl/sha256_pkg.sv -----
// sha256_pkg: SHA-256 round constants, initial hash values, sigma functions,
// command codes and the control bundle shared by the hasher's modules.
// No dependencies.
package sha256_pkg;

	typedef logic [7:0][31:0] word_arr_t;

	typedef struct packed {
		logic       shift_byte;
		logic [7:0] byte_in;
		logic       step;
		logic       init_v;
		logic       add_en;
		logic       load_iv;
		logic [5:0] rnd;
	} ctl_t;

	localparam logic CMD_DATA   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [5:0]  FILL_LAST  = 6'd63;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  RND_LAST   = 6'd63;
	localparam logic [2:0]  WORD_LAST  = 3'd7;
	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	localparam word_arr_t IV_WORDS = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// sha256_stream_hasher: byte-stream SHA-256 with padding sequencer and digest output.
// Depends on sha256_pkg, sha256_sched and sha256_core.
//
//   channel | signals                               | direction
//   in      | in_valid, in_stall, command, byte_value | into block
//   out     | out_valid, out_stall, digest_word,      | out of block
//           | word_index, last_word                 |
//
// A data byte shifts into the block buffer; the 64th byte of a block starts
// compression (64 rounds on the shared round unit, one feed-forward add).
// A finish adds pad and length bytes up to the block end, compresses one or
// two blocks, then emits eight output words.
// in_stall is high whenever the sequencer is not idle.
// Reset restores the initial hash values and clears the counters; no clearing pass.
// out_stall holds the current word; the sequencer waits for a free output register.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] msg_bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  widx_q;
	logic        fin_q;
	logic        first_q;
	logic        lenb_q;
	logic        out_valid_q;
	logic [31:0] digest_q;
	logic [2:0]  index_q;
	logic        last_q;

	ctl_t        ctl;
	logic [31:0] w_cur;
	word_arr_t   chain;
	logic [7:0]  pad_byte;
	logic        len_byte;
	logic        in_fire;
	logic        out_free;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = index_q;
	assign last_word   = last_q;

	assign len_byte = !first_q && lenb_q && (fill_q >= LEN_POS);
	assign pad_byte = first_q ? PAD_BYTE : (len_byte ? msg_bits_q[63:56] : 8'h00);

	always_comb begin
		ctl         = '0;
		ctl.rnd     = rnd_q;
		ctl.byte_in = byte_value;
		unique case (state_q)
			ST_IDLE: begin
				ctl.shift_byte = in_fire && (command == CMD_DATA);
				ctl.init_v     = in_fire && (command == CMD_DATA) && (fill_q == FILL_LAST);
			end
			ST_PAD: begin
				ctl.shift_byte = 1'b1;
				ctl.byte_in    = pad_byte;
				ctl.init_v     = (fill_q == FILL_LAST);
			end
			ST_COMP: ctl.step    = 1'b1;
			ST_ADD:  ctl.add_en  = 1'b1;
			ST_EMIT: ctl.load_iv = out_free && (widx_q == WORD_LAST);
			default: ctl = '0;
		endcase
	end

	sha256_sched u_sched (
		.clk   (clk),
		.ctl   (ctl),
		.w_cur (w_cur)
	);

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w_cur  (w_cur),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			msg_bits_q  <= '0;
			rnd_q       <= '0;
			widx_q      <= '0;
			fin_q       <= 1'b0;
			first_q     <= 1'b0;
			lenb_q      <= 1'b0;
			out_valid_q <= 1'b0;
			digest_q    <= '0;
			index_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (command == CMD_DATA) begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == FILL_LAST) begin
								msg_bits_q <= msg_bits_q + BLOCK_BITS;
								rnd_q      <= '0;
								state_q    <= ST_COMP;
							end
						end else begin
							msg_bits_q <= msg_bits_q + {55'd0, fill_q, 3'b000};
							fin_q      <= 1'b1;
							first_q    <= 1'b1;
							lenb_q     <= (fill_q < LEN_POS);
							state_q    <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					fill_q  <= fill_q + 6'd1;
					if (len_byte) begin
						msg_bits_q <= {msg_bits_q[55:0], 8'h00};
					end
					if (fill_q == FILL_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenb_q) begin
						widx_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						lenb_q  <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						digest_q    <= chain[widx_q];
						index_q     <= widx_q;
						last_q      <= (widx_q == WORD_LAST);
						widx_q      <= widx_q + 3'd1;
						if (widx_q == WORD_LAST) begin
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/sha256_sched.sv -----
// sha256_sched: 64-byte block buffer that doubles as the message schedule
// shift line; bytes shift in during collection, words expand during rounds.
// Depends on sha256_pkg.
module sha256_sched (
	input  logic               clk,
	input  sha256_pkg::ctl_t   ctl,
	output logic [31:0]        w_cur
);
	import sha256_pkg::*;

	logic [511:0] blk_q;
	logic [31:0]  w_new;

	assign w_cur = blk_q[511:480];
	assign w_new = small_sig1(blk_q[63:32]) + blk_q[223:192]
		+ small_sig0(blk_q[479:448]) + blk_q[511:480];

	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			blk_q <= {blk_q[503:0], ctl.byte_in};
		end else if (ctl.step) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

endmodule

// ----- rtl/sha256_core.sv -----
// sha256_core: one shared compression round applied once per cycle, plus the
// chaining value with its feed-forward add.
// Depends on sha256_pkg.
module sha256_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::ctl_t       ctl,
	input  logic [31:0]            w_cur,
	output sha256_pkg::word_arr_t  chain
);
	import sha256_pkg::*;

	word_arr_t   chain_q;
	word_arr_t   v_q;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign chain = chain_q;
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + big_sig1(v_q[4]) + ch + K_TAB[ctl.rnd] + w_cur;
	assign t2  = big_sig0(v_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= IV_WORDS;
		end else if (ctl.load_iv) begin
			chain_q <= IV_WORDS;
		end else if (ctl.add_en) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init_v) begin
			v_q <= chain_q;
		end else if (ctl.step) begin
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

endmodule

// ----- rtl/sha256_checker.sv -----
// sha256_checker: port-level checks on the hasher's transactions, bound to the top level.
// Depends on sha256_pkg and sha256_stream_hasher.
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        command,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	import sha256_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word)
			&& $stable(word_index) && $stable(last_word))
		else $error("stalled output transaction changed");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == WORD_LAST)))
		else $error("last_word does not match word_index");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_FINISH) |=> in_stall)
		else $error("input taken straight after a finish");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |-> in_stall)
		else $error("input open while digest words remain");

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (.*);
